// ===== design/fvr_pkg.sv =====
// ----------------------------------------------------------------------------
// fvr_pkg: shared types and constants
// Operation codes, status codes, sequencer states and field widths for the
// FIFO with delete-by-value.
// ----------------------------------------------------------------------------
package fvr_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int VALUE_W  = 32;
    localparam int KIND_W   = 2;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    // value, matches_res, occupancy, status, padded to whole bytes
    localparam int RES_W   = VALUE_W + COUNT_W + COUNT_W + STATUS_W;
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENQ = 2'd0,
        KIND_DEQ = 2'd1,
        KIND_CNT = 2'd2,
        KIND_REM = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE     = 2'd0,
        S_DEQ_WAIT = 2'd1,
        S_SCAN     = 2'd2,
        S_EMIT     = 2'd3
    } state_t;

endpackage

// ===== design/fvr_ram.sv =====
// ----------------------------------------------------------------------------
// fvr_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fvr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/fifo_with_value_removal_core.sv =====
// ----------------------------------------------------------------------------
// fifo_with_value_removal_core: FIFO of signed 32-bit words with
// count and delete by value, held as a circular buffer in one RAM.
// ----------------------------------------------------------------------------
// Enqueue goes from accept straight to S_EMIT; dequeue passes through S_DEQ_WAIT
// for the RAM read, unless the queue is empty. Count/remove: one comparator walks
// the stored entries, one RAM read per cycle, and remove compacts in place through
// the write port. One transaction at a time: s_tready is high only in S_IDLE.
// Reset (aresetn low, synchronous) empties the queue and drops any result;
// RAM contents are not cleared.
// ----------------------------------------------------------------------------
module fifo_with_value_removal_core #(
    parameter int DEPTH = fvr_pkg::DEPTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [fvr_pkg::VALUE_W-1:0]    s_tdata,  // [31:0] value
    input  logic [fvr_pkg::KIND_W-1:0]     s_tuser,  // [1:0] kind

    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [31:0] data, [36:32] matches_res, [41:37] occupancy, [43:42] status
    output logic [fvr_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int EXT_W  = CNT_W + fvr_pkg::COUNT_W;
    localparam int PAD_W  = fvr_pkg::M_TDATA_W - fvr_pkg::RES_W;

    // head + offset, folded back into the buffer
    function automatic logic [ADDR_W-1:0] wrap_idx(input logic [ADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0]  off);
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] fold;
        sum  = SUM_W'(base) + SUM_W'(off);
        fold = (sum >= SUM_W'(DEPTH)) ? (sum - SUM_W'(DEPTH)) : sum;
        return fold[ADDR_W-1:0];
    endfunction

    function automatic logic [fvr_pkg::COUNT_W-1:0] to_field(input logic [CNT_W-1:0] c);
        logic [EXT_W-1:0] e;
        e = EXT_W'(c);
        return e[fvr_pkg::COUNT_W-1:0];
    endfunction

    fvr_pkg::state_t                  state_reg,  state_next;
    fvr_pkg::kind_t                   kind_reg,   kind_next;
    logic [fvr_pkg::VALUE_W-1:0]      value_reg,  value_next;
    logic [ADDR_W-1:0]                head_reg,   head_next;
    logic [CNT_W-1:0]                 fill_reg,   fill_next;
    logic [CNT_W-1:0]                 rd_off_reg, rd_off_next;
    logic [CNT_W-1:0]                 wr_off_reg, wr_off_next;
    logic [CNT_W-1:0]                 match_reg,  match_next;
    logic                             pend_reg,   pend_next;
    logic [fvr_pkg::VALUE_W-1:0]      res_data_reg, res_data_next;
    fvr_pkg::status_t                 res_status_reg, res_status_next;

    logic                             m_valid_reg, m_valid_next;
    logic [fvr_pkg::M_TDATA_W-1:0]    m_data_reg,  m_data_next;

    logic                             ram_we;
    logic [ADDR_W-1:0]                ram_waddr;
    logic [fvr_pkg::VALUE_W-1:0]      ram_wdata;
    logic [ADDR_W-1:0]                ram_raddr;
    logic [fvr_pkg::VALUE_W-1:0]      ram_rdata;

    logic                             s_accept;
    logic                             out_free;
    logic                             full;
    logic                             empty;
    logic                             scan_issue;
    logic                             scan_done;
    logic                             is_match;
    fvr_pkg::kind_t                   s_kind;
    logic [ADDR_W-1:0]                head_inc;

    fvr_ram #(
        .WIDTH (fvr_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_kind     = fvr_pkg::kind_t'(s_tuser);
    assign s_tready   = (state_reg == fvr_pkg::S_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign out_free   = !m_valid_reg || m_tready;
    assign full       = (fill_reg == CNT_W'(DEPTH));
    assign empty      = (fill_reg == '0);
    assign scan_issue = (rd_off_reg < fill_reg);
    assign scan_done  = !scan_issue && !pend_reg;
    assign is_match   = (ram_rdata == value_reg);
    assign head_inc   = (head_reg == ADDR_W'(DEPTH - 1)) ? '0 : (head_reg + 1'b1);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fvr_pkg::S_IDLE: begin
                if (s_accept) begin
                    unique case (s_kind)
                        fvr_pkg::KIND_ENQ: state_next = fvr_pkg::S_EMIT;
                        fvr_pkg::KIND_DEQ: begin
                            state_next = empty ? fvr_pkg::S_EMIT : fvr_pkg::S_DEQ_WAIT;
                        end
                        fvr_pkg::KIND_CNT,
                        fvr_pkg::KIND_REM: state_next = fvr_pkg::S_SCAN;
                    endcase
                end
            end
            fvr_pkg::S_DEQ_WAIT: state_next = fvr_pkg::S_EMIT;
            fvr_pkg::S_SCAN: begin
                if (scan_done) begin
                    state_next = fvr_pkg::S_EMIT;
                end
            end
            fvr_pkg::S_EMIT: begin
                if (out_free) begin
                    state_next = fvr_pkg::S_IDLE;
                end
            end
        endcase
    end

    // datapath and RAM control
    always_comb begin
        kind_next       = kind_reg;
        value_next      = value_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        rd_off_next     = rd_off_reg;
        wr_off_next     = wr_off_reg;
        match_next      = match_reg;
        pend_next       = 1'b0;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = wrap_idx(head_reg, fill_reg);
        ram_wdata       = value_reg;
        ram_raddr       = head_reg;

        unique case (state_reg)
            fvr_pkg::S_IDLE: begin
                if (s_accept) begin
                    kind_next       = s_kind;
                    value_next      = s_tdata;
                    rd_off_next     = '0;
                    wr_off_next     = '0;
                    match_next      = '0;
                    res_data_next   = '0;
                    res_status_next = fvr_pkg::ST_OK;
                    unique case (s_kind)
                        fvr_pkg::KIND_ENQ: begin
                            if (full) begin
                                res_status_next = fvr_pkg::ST_OVERFLOW;
                            end else begin
                                ram_we    = 1'b1;
                                ram_wdata = s_tdata;
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        fvr_pkg::KIND_DEQ: begin
                            if (empty) begin
                                res_status_next = fvr_pkg::ST_EMPTY;
                            end else begin
                                head_next = head_inc;
                                fill_next = fill_reg - 1'b1;
                            end
                        end
                        fvr_pkg::KIND_CNT,
                        fvr_pkg::KIND_REM: begin
                        end
                    endcase
                end
            end
            fvr_pkg::S_DEQ_WAIT: begin
                res_data_next = ram_rdata;
            end
            fvr_pkg::S_SCAN: begin
                // read ahead one entry while the previous one is compared
                ram_raddr = wrap_idx(head_reg, rd_off_reg);
                if (scan_issue) begin
                    rd_off_next = rd_off_reg + 1'b1;
                    pend_next   = 1'b1;
                end
                if (pend_reg) begin
                    if (is_match) begin
                        match_next = match_reg + 1'b1;
                    end else if (kind_reg == fvr_pkg::KIND_REM) begin
                        // compaction: write slot always trails the read slot
                        ram_we      = 1'b1;
                        ram_waddr   = wrap_idx(head_reg, wr_off_reg);
                        ram_wdata   = ram_rdata;
                        wr_off_next = wr_off_reg + 1'b1;
                    end
                end
                if (scan_done && kind_reg == fvr_pkg::KIND_REM) begin
                    fill_next = wr_off_reg;
                end
            end
            fvr_pkg::S_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{PAD_W{1'b0}}, res_status_reg, to_field(fill_reg),
                                    to_field(match_reg), res_data_reg};
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fvr_pkg::S_IDLE;
            head_reg    <= '0;
            fill_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            fill_reg    <= fill_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        value_reg      <= value_next;
        rd_off_reg     <= rd_off_next;
        wr_off_reg     <= wr_off_next;
        match_reg      <= match_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(DEPTH))
        else $error("fill exceeds depth");

    a_compact_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fvr_pkg::S_SCAN) |-> (wr_off_reg <= rd_off_reg))
        else $error("compaction write overtook read");

    a_scan_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fvr_pkg::S_SCAN) |->
            ({1'b0, match_reg} + {1'b0, wr_off_reg} <= {1'b0, rd_off_reg}))
        else $error("scan counts exceed entries read");

    a_enq_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_kind == fvr_pkg::KIND_ENQ && !full) |=>
            (fill_reg == $past(fill_reg) + 1'b1))
        else $error("enqueue did not grow the queue");

    a_result_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == fvr_pkg::S_EMIT))
        else $error("result raised outside emit");

endmodule
